>>> rtl/core/gpts_pkg.sv
// ---------------------------------------------------------------------------
// gpts_pkg
// shared types and constants of the gameport axis timer and scaler
// ---------------------------------------------------------------------------
package gpts_pkg;

   // configuration register widths
   localparam int TIMEOUT_W = 12;
   localparam int CENTER_W  = 12;
   localparam int MINIMUM_W = 12;
   localparam int MAXIMUM_W = 13;
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 3;

   // result field widths
   localparam int RAW_W    = 12;
   localparam int SCALED_W = 20;
   localparam int BTN_W    = 4;
   localparam int PORT_W   = 8;

   // centred value is multiplied by 128 before the division
   localparam int SCALE_SHIFT = 7;

   // signed difference of two calibration values, divisor width
   localparam int DIFF_W    = MAXIMUM_W + 1;
   localparam int DIVISOR_W = MAXIMUM_W;

   // axis timer bits of the port byte
   localparam logic [3:0] AXIS_NIBBLE = 4'hf;

   // reset values of the configuration registers
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 12'd1200;
   localparam logic [CENTER_W-1:0]  CENTER_RST  = 12'd300;
   localparam logic [MINIMUM_W-1:0] MINIMUM_RST = 12'd0;
   localparam logic [MAXIMUM_W-1:0] MAXIMUM_RST = 13'd600;

   // configuration register indexes
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_TIMEOUT   = 3'd0;
   localparam csr_idx_type CSR_CENTER_X  = 3'd1;
   localparam csr_idx_type CSR_CENTER_Y  = 3'd2;
   localparam csr_idx_type CSR_MINIMUM_X = 3'd3;
   localparam csr_idx_type CSR_MINIMUM_Y = 3'd4;
   localparam csr_idx_type CSR_MAXIMUM_X = 3'd5;
   localparam csr_idx_type CSR_MAXIMUM_Y = 3'd6;

endpackage

>>> rtl/core/gameport_axis_timer_scaler.sv
// ---------------------------------------------------------------------------
// gameport_axis_timer_scaler
// times the two stick axes of a polled gameport and centres them
// ---------------------------------------------------------------------------
//
// channel  | ports                                   | direction
// ---------+-----------------------------------------+-----------
// req      | req_valid/req_ready, port_sample, start | in
// rsp      | rsp_valid/rsp_ready, raw, scaled, btns  | out
// csr      | csr_we, csr_index, csr_wdata            | in (write only)
//
// a sample that does not end a measurement is taken with req_ready held high
// a sample that ends one holds req_ready low through the setup, divide,
// store and output steps of the shared restoring divider
// that works one quotient bit per cycle, x axis first, then y; an axis
// with no usable divisor skips its MAG_W divide steps
// the result then waits in the output register; a new sample is taken
// meanwhile, and a second ending sample runs the divider, then holds
// req_ready low until the first result is taken
// reset is synchronous and loads the documented calibration defaults
//
module gameport_axis_timer_scaler #(
   parameter int COUNT_BITS = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // sample channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [gpts_pkg::PORT_W-1:0]             req_port_sample,
   input  logic                                    req_start_req,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [gpts_pkg::RAW_W-1:0]              rsp_raw_x,
   output logic [gpts_pkg::RAW_W-1:0]              rsp_raw_y,
   output logic signed [gpts_pkg::SCALED_W-1:0]    rsp_scaled_x,
   output logic signed [gpts_pkg::SCALED_W-1:0]    rsp_scaled_y,
   output logic [gpts_pkg::BTN_W-1:0]              rsp_buttons,
   // configuration port
   input  logic                                    csr_we,
   input  logic [gpts_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [gpts_pkg::CSR_W-1:0]              csr_wdata
);

   // widths derived from the counter size
   localparam int AXIS_W = (COUNT_BITS > gpts_pkg::TIMEOUT_W) ? COUNT_BITS
                                                              : gpts_pkg::TIMEOUT_W;
   localparam int AV_W   = AXIS_W + 1;                      // signed raw - centre
   localparam int MAG_W  = AXIS_W + gpts_pkg::SCALE_SHIFT;  // dividend width
   localparam int CMP_W  = AXIS_W + 1;                      // index + 1 vs timeout
   localparam int CNT_W  = (MAG_W > 1) ? $clog2(MAG_W) : 1;
   localparam logic [COUNT_BITS-1:0] IDX_FULL = {COUNT_BITS{1'b1}};

   // sequencer codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SETUP = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_STORE = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   logic [gpts_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [gpts_pkg::CENTER_W-1:0]  center_x_ff, center_y_ff;
   logic [gpts_pkg::MINIMUM_W-1:0] minimum_x_ff, minimum_y_ff;
   logic [gpts_pkg::MAXIMUM_W-1:0] maximum_x_ff, maximum_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= gpts_pkg::TIMEOUT_RST;
         center_x_ff  <= gpts_pkg::CENTER_RST;
         center_y_ff  <= gpts_pkg::CENTER_RST;
         minimum_x_ff <= gpts_pkg::MINIMUM_RST;
         minimum_y_ff <= gpts_pkg::MINIMUM_RST;
         maximum_x_ff <= gpts_pkg::MAXIMUM_RST;
         maximum_y_ff <= gpts_pkg::MAXIMUM_RST;
      end else if (csr_we) begin
         // indexes past the list are dropped
         case (csr_index)
            gpts_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_wdata[gpts_pkg::TIMEOUT_W-1:0];
            gpts_pkg::CSR_CENTER_X:  center_x_ff  <= csr_wdata[gpts_pkg::CENTER_W-1:0];
            gpts_pkg::CSR_CENTER_Y:  center_y_ff  <= csr_wdata[gpts_pkg::CENTER_W-1:0];
            gpts_pkg::CSR_MINIMUM_X: minimum_x_ff <= csr_wdata[gpts_pkg::MINIMUM_W-1:0];
            gpts_pkg::CSR_MINIMUM_Y: minimum_y_ff <= csr_wdata[gpts_pkg::MINIMUM_W-1:0];
            gpts_pkg::CSR_MAXIMUM_X: maximum_x_ff <= csr_wdata[gpts_pkg::MAXIMUM_W-1:0];
            gpts_pkg::CSR_MAXIMUM_Y: maximum_y_ff <= csr_wdata[gpts_pkg::MAXIMUM_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // measurement state
   // ------------------------------------------------------------------------
   logic [2:0]              state_ff, state_in;
   logic                    meas_ff, meas_in;
   logic [COUNT_BITS-1:0]   idx_ff, idx_in;
   logic [3:0]              prev_ff, prev_in;
   logic [COUNT_BITS-1:0]   edge_x_ff, edge_x_in;
   logic [COUNT_BITS-1:0]   edge_y_ff, edge_y_in;
   logic [gpts_pkg::BTN_W-1:0] btn_or_ff, btn_or_in;

   // divider and sequencer
   logic                    axis_ff, axis_in;      // 0 = x, 1 = y
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [MAG_W-1:0]        quo_ff, quo_in;
   logic [gpts_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [gpts_pkg::DIVISOR_W-1:0] div_ff, div_in;
   logic                    neg_ff, neg_in;
   logic [gpts_pkg::SCALED_W-1:0] sx_ff, sx_in;
   logic [gpts_pkg::SCALED_W-1:0] sy_ff, sy_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [gpts_pkg::RAW_W-1:0]    rsp_raw_x_ff, rsp_raw_x_in;
   logic [gpts_pkg::RAW_W-1:0]    rsp_raw_y_ff, rsp_raw_y_in;
   logic [gpts_pkg::SCALED_W-1:0] rsp_sx_ff, rsp_sx_in;
   logic [gpts_pkg::SCALED_W-1:0] rsp_sy_ff, rsp_sy_in;
   logic [gpts_pkg::BTN_W-1:0]    rsp_btn_ff, rsp_btn_in;

   // sample path
   logic                    req_fire;
   logic                    meas_c;
   logic [COUNT_BITS-1:0]   idx_c;
   logic [3:0]              prev_c, bits_c;
   logic [COUNT_BITS-1:0]   edge_x_c, edge_y_c;
   logic [gpts_pkg::BTN_W-1:0] btn_or_c;
   logic [CMP_W-1:0]        next_idx_c;
   logic                    done_c;

   // setup path
   logic [COUNT_BITS-1:0]          raw_sel;
   logic [gpts_pkg::CENTER_W-1:0]  ctr_sel;
   logic [gpts_pkg::MINIMUM_W-1:0] lo_sel;
   logic [gpts_pkg::MAXIMUM_W-1:0] hi_sel;
   logic signed [AV_W-1:0]         av_c;
   logic [AV_W-1:0]                av_abs;
   logic [AV_W-2:0]                mag_c;
   logic signed [gpts_pkg::DIFF_W-1:0] d_lo, d_hi, d_c;
   logic                           d_pos;

   // divider step
   logic [gpts_pkg::DIVISOR_W:0]   shifted_c;
   logic [gpts_pkg::DIVISOR_W+1:0] diff_c;
   logic                           fits_c;
   logic [gpts_pkg::SCALED_W-1:0]  q_ext, q_signed;
   logic                           out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // a start flag restarts from the reset values of the measurement
   always_comb begin
      meas_c   = req_start_req || meas_ff;
      idx_c    = req_start_req ? '0 : idx_ff;
      prev_c   = req_start_req ? gpts_pkg::AXIS_NIBBLE : prev_ff;
      edge_x_c = req_start_req ? '0 : edge_x_ff;
      edge_y_c = req_start_req ? '0 : edge_y_ff;
      btn_or_c = (req_start_req ? '0 : btn_or_ff) | req_port_sample[7:4];
      bits_c   = req_port_sample[3:0] & gpts_pkg::AXIS_NIBBLE;
      // falling edge of an axis bit records the sample index
      if (!bits_c[0] && prev_c[0]) begin
         edge_x_c = idx_c;
      end
      if (!bits_c[1] && prev_c[1]) begin
         edge_y_c = idx_c;
      end
      next_idx_c = CMP_W'(idx_c) + CMP_W'(1);
      done_c     = (bits_c == 4'h0) || (next_idx_c >= CMP_W'(timeout_ff))
                   || (idx_c == IDX_FULL);
   end

   // axis operands for the divider
   always_comb begin
      raw_sel = axis_ff ? edge_y_ff    : edge_x_ff;
      ctr_sel = axis_ff ? center_y_ff  : center_x_ff;
      lo_sel  = axis_ff ? minimum_y_ff : minimum_x_ff;
      hi_sel  = axis_ff ? maximum_y_ff : maximum_x_ff;
      av_c    = $signed(AV_W'(raw_sel)) - $signed(AV_W'(ctr_sel));
      av_abs  = av_c[AV_W-1] ? AV_W'(-av_c) : AV_W'(av_c);
      mag_c   = av_abs[AV_W-2:0];
      d_lo    = $signed(gpts_pkg::DIFF_W'(ctr_sel)) - $signed(gpts_pkg::DIFF_W'(lo_sel));
      d_hi    = $signed(gpts_pkg::DIFF_W'(hi_sel)) - $signed(gpts_pkg::DIFF_W'(ctr_sel));
      d_c     = av_c[AV_W-1] ? d_lo : d_hi;
      d_pos   = !d_c[gpts_pkg::DIFF_W-1] && (d_c != '0);
   end

   // one restoring step: shift in the next dividend bit, trial subtract
   always_comb begin
      shifted_c = {rem_ff, quo_ff[MAG_W-1]};
      diff_c    = {1'b0, shifted_c} - {2'b00, div_ff};
      fits_c    = !diff_c[gpts_pkg::DIVISOR_W+1];
      q_ext     = gpts_pkg::SCALED_W'(quo_ff);
      q_signed  = neg_ff ? (~q_ext + gpts_pkg::SCALED_W'(1)) : q_ext;
   end

   always_comb begin
      state_in     = state_ff;
      meas_in      = meas_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      edge_x_in    = edge_x_ff;
      edge_y_in    = edge_y_ff;
      btn_or_in    = btn_or_ff;
      axis_in      = axis_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      neg_in       = neg_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_raw_x_in = rsp_raw_x_ff;
      rsp_raw_y_in = rsp_raw_y_ff;
      rsp_sx_in    = rsp_sx_ff;
      rsp_sy_in    = rsp_sy_ff;
      rsp_btn_in   = rsp_btn_ff;

      case (state_ff)
         ST_IDLE: begin
            // samples outside a measurement without a start flag are dropped
            if (req_fire && meas_c) begin
               idx_in    = next_idx_c[COUNT_BITS-1:0];
               prev_in   = bits_c;
               edge_x_in = edge_x_c;
               edge_y_in = edge_y_c;
               btn_or_in = btn_or_c;
               meas_in   = !done_c;
               if (done_c) begin
                  axis_in  = 1'b0;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            neg_in = av_c[AV_W-1];
            div_in = d_c[gpts_pkg::DIVISOR_W-1:0];
            rem_in = '0;
            cnt_in = CNT_W'(MAG_W - 1);
            if (d_pos) begin
               quo_in   = {mag_c, {gpts_pkg::SCALE_SHIFT{1'b0}}};
               state_in = ST_DIV;
            end else begin
               // no usable divisor: pass the centred value through
               quo_in   = MAG_W'(mag_c);
               state_in = ST_STORE;
            end
         end
         ST_DIV: begin
            rem_in = fits_c ? diff_c[gpts_pkg::DIVISOR_W-1:0]
                            : shifted_c[gpts_pkg::DIVISOR_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], fits_c};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (!axis_ff) begin
               sx_in    = q_signed;
               axis_in  = 1'b1;
               state_in = ST_SETUP;
            end else begin
               // the output register may still hold a transaction here
               sy_in    = q_signed;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the output register to drain
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_raw_x_in = gpts_pkg::RAW_W'(edge_x_ff);
               rsp_raw_y_in = gpts_pkg::RAW_W'(edge_y_ff);
               rsp_sx_in    = sx_ff;
               rsp_sy_in    = sy_ff;
               rsp_btn_in   = ~btn_or_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         meas_ff      <= 1'b0;
         idx_ff       <= '0;
         prev_ff      <= gpts_pkg::AXIS_NIBBLE;
         edge_x_ff    <= '0;
         edge_y_ff    <= '0;
         btn_or_ff    <= '0;
         axis_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         meas_ff      <= meas_in;
         idx_ff       <= idx_in;
         prev_ff      <= prev_in;
         edge_x_ff    <= edge_x_in;
         edge_y_ff    <= edge_y_in;
         btn_or_ff    <= btn_or_in;
         axis_ff      <= axis_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      neg_ff       <= neg_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      rsp_raw_x_ff <= rsp_raw_x_in;
      rsp_raw_y_ff <= rsp_raw_y_in;
      rsp_sx_ff    <= rsp_sx_in;
      rsp_sy_ff    <= rsp_sy_in;
      rsp_btn_ff   <= rsp_btn_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_raw_x    = rsp_raw_x_ff;
   assign rsp_raw_y    = rsp_raw_y_ff;
   assign rsp_scaled_x = $signed(rsp_sx_ff);
   assign rsp_scaled_y = $signed(rsp_sy_ff);
   assign rsp_buttons  = rsp_btn_ff;

`ifndef ASSERT_OFF
   // no measurement stays open while the divider runs
   a_meas_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !meas_ff)
      else $error("measurement open while dividing");

   // an ending sample starts the x axis division next cycle
   a_end_starts_div: assert property (@(posedge clock) disable iff (reset)
      (req_fire && meas_c && done_c) |=> (state_ff == ST_SETUP && !axis_ff))
      else $error("ending sample did not start the divider");

   // a new transaction is only raised from the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (!$past(rsp_valid) || $past(rsp_ready)))
         |-> ($past(state_ff) == ST_OUT))
      else $error("result raised outside output step");

   // bit counter never leaves the dividend range while dividing
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= CNT_W'(MAG_W - 1)))
      else $error("divider step count out of range");
`endif

endmodule
